[design/blf_pkg.sv]
// ----------------------------------------------------------------------------
// blf_pkg: beam local frame rotation package
// Widths, fixed-point constants and the pipeline payload type.
// ----------------------------------------------------------------------------
`default_nettype none

package blf_pkg;

  localparam int CW   = 32;        // coordinate width
  localparam int DW   = CW + 1;    // difference / magnitude width
  localparam int SW   = 2 * DW;    // sum of squares width
  localparam int LW   = DW;        // square root width
  localparam int RRW  = LW + 3;    // square root remainder width
  localparam int DRW  = LW + 1;    // cosine divider remainder width
  localparam int MF   = 16;        // matrix fraction bits
  localparam int QW   = MF + 1;    // cosine magnitude width
  localparam int EW   = MF + 2;    // matrix entry width
  localparam int TW   = EW;        // 1 + lx width
  localparam int NW   = 2 * QW;    // product / numerator width
  localparam int KW   = EW;        // quotient width
  localparam int KRW  = TW + 1;    // quotient remainder width
  localparam int SXW  = EW + 2;    // entry arithmetic width
  localparam int LENW = 34;        // output length width
  localparam int INW  = 6 * CW;
  localparam int OUTW = ((LENW + 9 * EW + 7) / 8) * 8;

  localparam logic [EW-1:0] ONE     = EW'(1 << MF);
  localparam logic [EW-1:0] NEG_ONE = EW'(-(1 << MF));
  localparam logic [KW-1:0] QMAX    = KW'((2 << MF) + 1);

  typedef struct packed {
    logic                  mode;
    logic [2:0]            neg;
    logic [2:0][DW-1:0]    mag;
    logic [2:0][SW-1:0]    sq;
    logic [SW-1:0]         s;
    logic [RRW-1:0]        rr;
    logic [LW-1:0]         len;
    logic [2:0][DRW-1:0]   dr;
    logic [2:0][QW-1:0]    dq;
    logic [2:0][EW-1:0]    l;
    logic                  degen;
    logic [TW-1:0]         t;
    logic [2:0][NW-1:0]    n;
    logic [2:0][KRW-1:0]   kr;
    logic [2:0]            ovf;
    logic [2:0][KW-1:0]    kq;
    logic [8:0][EW-1:0]    e;
  } pl_t;

endpackage

`default_nettype wire

[design/beam_local_frame_rotation.sv]
// ----------------------------------------------------------------------------
// beam_local_frame_rotation
// Beam length and local frame rotation matrix from two node coordinates.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per clock, while the output is not stalled,
// through 76 register stages. The depth is set by the bit-per-stage square
// root (33 stages), the bit-per-stage cosine dividers (17 stages) and the
// bit-per-stage quotient dividers for the spatial terms (18 stages). A
// stalled output freezes the whole pipeline.
`default_nettype none

module beam_local_frame_rotation (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z
  input  wire logic [blf_pkg::INW-1:0]   s_axis_tdata,
  // mode
  input  wire logic [0:0]                s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // beam_length, r00, r01, r02, r10, r11, r12, r20, r21, r22, zero pad
  output logic [blf_pkg::OUTW-1:0]       m_axis_tdata,
  // degenerate
  output logic [0:0]                     m_axis_tuser
);

  localparam int SQ0 = 3;
  localparam int D0  = SQ0 + blf_pkg::LW;
  localparam int DV0 = D0 + 1;
  localparam int RND = DV0 + blf_pkg::QW;
  localparam int PRD = RND + 1;
  localparam int ADD = PRD + 1;
  localparam int QS0 = ADD + 1;
  localparam int FIN = QS0 + blf_pkg::KW;
  localparam int NST = FIN + 1;

  localparam logic signed [blf_pkg::SXW-1:0] ONE_SX = blf_pkg::SXW'(1 << blf_pkg::MF);

  blf_pkg::pl_t pl [NST];
  blf_pkg::pl_t pl_next [NST];
  logic [NST-1:0] v;
  logic en;

  function automatic logic [blf_pkg::EW-1:0] sat_unit(input logic signed [blf_pkg::SXW-1:0] x);
    logic signed [blf_pkg::SXW-1:0] y;
    y = x;
    if (x > ONE_SX) y = ONE_SX;
    if (x < -ONE_SX) y = -ONE_SX;
    return y[blf_pkg::EW-1:0];
  endfunction

  assign en            = !v[NST-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    logic [blf_pkg::CW-1:0] a;
    logic [blf_pkg::CW-1:0] b;
    logic [blf_pkg::DW-1:0] d;
    pl_next[0]      = '0;
    pl_next[0].mode = s_axis_tuser[0];
    for (int c = 0; c < 3; c++) begin
      a = s_axis_tdata[c*blf_pkg::CW +: blf_pkg::CW];
      b = s_axis_tdata[(c+3)*blf_pkg::CW +: blf_pkg::CW];
      d = {b[blf_pkg::CW-1], b} - {a[blf_pkg::CW-1], a};
      pl_next[0].neg[c] = d[blf_pkg::DW-1];
      pl_next[0].mag[c] = d[blf_pkg::DW-1] ? -d : d;
    end
  end

  for (genvar k = 1; k < NST; k++) begin : g_st
    if (k == 1) begin : g_sq
      always_comb begin
        pl_next[k] = pl[k-1];
        for (int c = 0; c < 3; c++) begin
          pl_next[k].sq[c] = blf_pkg::SW'(pl[k-1].mag[c]) * blf_pkg::SW'(pl[k-1].mag[c]);
        end
      end
    end else if (k == 2) begin : g_sum
      always_comb begin
        pl_next[k]     = pl[k-1];
        pl_next[k].s   = pl[k-1].sq[0] + pl[k-1].sq[1] + pl[k-1].sq[2];
        pl_next[k].rr  = '0;
        pl_next[k].len = '0;
      end
    end else if (k < D0) begin : g_sqrt
      localparam int I = blf_pkg::LW - 1 - (k - SQ0);
      always_comb begin
        logic [blf_pkg::RRW-1:0] r2;
        logic [blf_pkg::RRW-1:0] tr;
        pl_next[k] = pl[k-1];
        r2 = {pl[k-1].rr[blf_pkg::RRW-3:0], pl[k-1].s[2*I+1], pl[k-1].s[2*I]};
        tr = {1'b0, pl[k-1].len, 2'b01};
        if (r2 >= tr) begin
          pl_next[k].rr  = r2 - tr;
          pl_next[k].len = {pl[k-1].len[blf_pkg::LW-2:0], 1'b1};
        end else begin
          pl_next[k].rr  = r2;
          pl_next[k].len = {pl[k-1].len[blf_pkg::LW-2:0], 1'b0};
        end
      end
    end else if (k == D0) begin : g_dinit
      always_comb begin
        pl_next[k] = pl[k-1];
        for (int c = 0; c < 3; c++) begin
          pl_next[k].dr[c] = blf_pkg::DRW'(pl[k-1].mag[c] >> 1);
          pl_next[k].dq[c] = '0;
        end
      end
    end else if (k < RND) begin : g_cdiv
      localparam int B = blf_pkg::QW - 1 - (k - DV0);
      always_comb begin
        logic [blf_pkg::DRW-1:0] r2;
        logic                    bi;
        pl_next[k] = pl[k-1];
        for (int c = 0; c < 3; c++) begin
          bi = (B == blf_pkg::MF) ? pl[k-1].mag[c][0] : 1'b0;
          r2 = {pl[k-1].dr[c][blf_pkg::DRW-2:0], bi};
          if (r2 >= {1'b0, pl[k-1].len}) begin
            pl_next[k].dr[c] = r2 - {1'b0, pl[k-1].len};
            pl_next[k].dq[c] = {pl[k-1].dq[c][blf_pkg::QW-2:0], 1'b1};
          end else begin
            pl_next[k].dr[c] = r2;
            pl_next[k].dq[c] = {pl[k-1].dq[c][blf_pkg::QW-2:0], 1'b0};
          end
        end
      end
    end else if (k == RND) begin : g_rnd
      always_comb begin
        logic [blf_pkg::QW:0] qq;
        logic [blf_pkg::EW-1:0] lv;
        pl_next[k] = pl[k-1];
        for (int c = 0; c < 3; c++) begin
          qq = {1'b0, pl[k-1].dq[c]};
          if ({pl[k-1].dr[c], 1'b0} >= {2'b00, pl[k-1].len}) qq = qq + 1'b1;
          if (qq > (blf_pkg::QW+1)'(blf_pkg::ONE)) qq = (blf_pkg::QW+1)'(blf_pkg::ONE);
          pl_next[k].dq[c] = qq[blf_pkg::QW-1:0];
          lv = blf_pkg::EW'(qq);
          pl_next[k].l[c] = pl[k-1].neg[c] ? -lv : lv;
        end
        pl_next[k].degen = (pl[k-1].len == '0) ||
                           (pl[k-1].mode && pl_next[k].l[0] == blf_pkg::NEG_ONE);
        pl_next[k].t = pl_next[k].l[0] + blf_pkg::ONE;
      end
    end else if (k == PRD) begin : g_prd
      always_comb begin
        pl_next[k] = pl[k-1];
        pl_next[k].n[0] = blf_pkg::NW'(pl[k-1].dq[1]) * blf_pkg::NW'(pl[k-1].dq[1]);
        pl_next[k].n[1] = blf_pkg::NW'(pl[k-1].dq[2]) * blf_pkg::NW'(pl[k-1].dq[2]);
        pl_next[k].n[2] = blf_pkg::NW'(pl[k-1].dq[1]) * blf_pkg::NW'(pl[k-1].dq[2]);
      end
    end else if (k == ADD) begin : g_add
      always_comb begin
        logic [blf_pkg::NW-1:0] nn;
        pl_next[k] = pl[k-1];
        for (int c = 0; c < 3; c++) begin
          nn = pl[k-1].n[c] + blf_pkg::NW'(pl[k-1].t >> 1);
          pl_next[k].n[c]   = nn;
          pl_next[k].kr[c]  = blf_pkg::KRW'(nn >> blf_pkg::KW);
          pl_next[k].ovf[c] = blf_pkg::KRW'(nn >> blf_pkg::KW) >= {1'b0, pl[k-1].t};
          pl_next[k].kq[c]  = '0;
        end
      end
    end else if (k < FIN) begin : g_qdiv
      localparam int B = blf_pkg::KW - 1 - (k - QS0);
      always_comb begin
        logic [blf_pkg::KRW-1:0] r2;
        pl_next[k] = pl[k-1];
        for (int c = 0; c < 3; c++) begin
          r2 = {pl[k-1].kr[c][blf_pkg::KRW-2:0], pl[k-1].n[c][B]};
          if (r2 >= {1'b0, pl[k-1].t}) begin
            pl_next[k].kr[c] = r2 - {1'b0, pl[k-1].t};
            pl_next[k].kq[c] = {pl[k-1].kq[c][blf_pkg::KW-2:0], 1'b1};
          end else begin
            pl_next[k].kr[c] = r2;
            pl_next[k].kq[c] = {pl[k-1].kq[c][blf_pkg::KW-2:0], 1'b0};
          end
        end
      end
    end else begin : g_fin
      always_comb begin
        logic [blf_pkg::KW-1:0] q [3];
        logic signed [blf_pkg::SXW-1:0] lx;
        logic signed [blf_pkg::SXW-1:0] ly;
        logic signed [blf_pkg::SXW-1:0] lz;
        logic pos;
        logic [blf_pkg::EW-1:0] x12;
        pl_next[k] = pl[k-1];
        for (int c = 0; c < 3; c++) begin
          q[c] = (pl[k-1].ovf[c] || pl[k-1].kq[c] > blf_pkg::QMAX) ?
                 blf_pkg::QMAX : pl[k-1].kq[c];
        end
        lx  = blf_pkg::SXW'($signed(pl[k-1].l[0]));
        ly  = blf_pkg::SXW'($signed(pl[k-1].l[1]));
        lz  = blf_pkg::SXW'($signed(pl[k-1].l[2]));
        pos = (ly > 0 && lz > 0) || (ly < 0 && lz < 0);
        x12 = sat_unit(pos ? -blf_pkg::SXW'(q[2]) : blf_pkg::SXW'(q[2]));
        pl_next[k].e    = '0;
        pl_next[k].e[0] = blf_pkg::ONE;
        pl_next[k].e[4] = blf_pkg::ONE;
        pl_next[k].e[8] = blf_pkg::ONE;
        if (!pl[k-1].degen) begin
          if (!pl[k-1].mode) begin
            pl_next[k].e[0] = pl[k-1].l[0];
            pl_next[k].e[1] = pl[k-1].l[1];
            pl_next[k].e[3] = -pl[k-1].l[1];
            pl_next[k].e[4] = pl[k-1].l[0];
          end else begin
            pl_next[k].e[0] = lx[blf_pkg::EW-1:0];
            pl_next[k].e[1] = pl[k-1].l[1];
            pl_next[k].e[2] = pl[k-1].l[2];
            pl_next[k].e[3] = -pl[k-1].l[1];
            pl_next[k].e[6] = -pl[k-1].l[2];
            pl_next[k].e[4] = sat_unit(ONE_SX - blf_pkg::SXW'(q[0]));
            pl_next[k].e[8] = sat_unit(ONE_SX - blf_pkg::SXW'(q[1]));
            pl_next[k].e[5] = x12;
            pl_next[k].e[7] = x12;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-2:0], s_axis_tvalid};
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en) begin
        pl[k] <= pl_next[k];
      end
    end
  end

  assign m_axis_tvalid = v[NST-1];
  assign m_axis_tuser  = pl[NST-1].degen;
  assign m_axis_tdata  = blf_pkg::OUTW'({pl[NST-1].e, blf_pkg::LENW'(pl[NST-1].len)});

  a_degen_identity: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      pl[NST-1].e[0] == blf_pkg::ONE && pl[NST-1].e[4] == blf_pkg::ONE &&
      pl[NST-1].e[8] == blf_pkg::ONE && pl[NST-1].e[1] == '0 && pl[NST-1].e[5] == '0)
    else $error("degenerate result is not the identity");

  a_zero_len_degen: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && pl[NST-1].len == '0 |-> m_axis_tuser[0])
    else $error("zero length without degenerate flag");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(pl[NST-1].e))
    else $error("stalled result changed");

endmodule

`default_nettype wire
